/* src/asvp_pkg.sv */
// Shared constants, types and the sine table builder for the alarm siren unit.
package asvp_pkg;

  localparam int PHASE_BITS  = 32;
  localparam int SINE_DEPTH  = 1024;
  localparam int SINE_IDX_W  = $clog2(SINE_DEPTH);
  localparam int SAMPLE_W    = 16;
  localparam int CHUNK_W     = 24;
  localparam int VIB_W       = 24;
  localparam int LEN_W       = 32;
  localparam int STEP_W      = 31;
  localparam int PADDR_W     = 5;
  localparam int PDATA_W     = 32;

  localparam logic [63:0] AMPLITUDE   = 64'd24000;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] Q30_ONE     = 64'd1073741824;

  // Factorial steps of the sine series: (2n)(2n+1) for n = 1..6.
  localparam logic [63:0] TAYLOR_DIV [1:6] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156};

  typedef enum logic [2:0] {
    REG_STEP_HIGH = 3'd0,
    REG_STEP_LOW  = 3'd1,
    REG_CHUNK     = 3'd2,
    REG_VIB_ON    = 3'd3,
    REG_VIB_OFF   = 3'd4,
    REG_ALARM_LEN = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [STEP_W-1:0]  phase_step_high;
    logic [STEP_W-1:0]  phase_step_low;
    logic [CHUNK_W-1:0] tone_chunk_frames;
    logic [VIB_W-1:0]   vibrate_on_frames;
    logic [VIB_W-1:0]   vibrate_off_frames;
    logic [LEN_W-1:0]   alarm_length_frames;
  } cfg_t;

  typedef struct packed {
    logic active;
    logic motor_pulse;
    logic vibrating;
    logic finished;
  } flags_t;

  typedef logic signed [SAMPLE_W-1:0] sine_rom_t [SINE_DEPTH];

  // Quarter-wave Taylor series in Q30, rounded half up and clamped to the amplitude.
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t   rom;
    logic [63:0] u;
    logic [63:0] q;
    logic [63:0] r;
    logic [63:0] x;
    logic [63:0] sum;
    logic [63:0] t;
    logic [63:0] m;
    for (int i = 0; i < SINE_DEPTH; i++) begin
      u = 64'(i) * 64'd4;
      q = u / 64'(SINE_DEPTH);
      r = u - q * 64'(SINE_DEPTH);
      if (q[0]) r = 64'(SINE_DEPTH) - r;
      x = (HALF_PI_Q30 * r) / 64'(SINE_DEPTH);
      sum = x;
      t = x;
      for (int n = 1; n <= 6; n++) begin
        t = (t * x) >> 30;
        t = (t * x) >> 30;
        t = t / TAYLOR_DIV[n];
        if (n[0]) sum = (sum >= t) ? sum - t : 64'd0;
        else sum = sum + t;
      end
      m = (sum * AMPLITUDE + (Q30_ONE >> 1)) >> 30;
      if (m > AMPLITUDE) m = AMPLITUDE;
      rom[i] = (q >= 64'd2) ? SAMPLE_W'(64'd0 - m) : SAMPLE_W'(m);
    end
    return rom;
  endfunction

endpackage

/* src/asvp_regs.sv */
// Configuration register file behind the APB-style port.
module asvp_regs import asvp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg
);

  reg_idx_t reg_sel;
  logic     wr_en;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[PADDR_W-1:2]);
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.phase_step_high     <= '0;
      cfg.phase_step_low      <= '0;
      cfg.tone_chunk_frames   <= CHUNK_W'(1);
      cfg.vibrate_on_frames   <= VIB_W'(1);
      cfg.vibrate_off_frames  <= VIB_W'(1);
      cfg.alarm_length_frames <= LEN_W'(1);
    end else if (wr_en) begin
      case (reg_sel)
        REG_STEP_HIGH: cfg.phase_step_high     <= pwdata[STEP_W-1:0];
        REG_STEP_LOW:  cfg.phase_step_low      <= pwdata[STEP_W-1:0];
        REG_CHUNK:     cfg.tone_chunk_frames   <= pwdata[CHUNK_W-1:0];
        REG_VIB_ON:    cfg.vibrate_on_frames   <= pwdata[VIB_W-1:0];
        REG_VIB_OFF:   cfg.vibrate_off_frames  <= pwdata[VIB_W-1:0];
        REG_ALARM_LEN: cfg.alarm_length_frames <= pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_STEP_HIGH: prdata = PDATA_W'(cfg.phase_step_high);
      REG_STEP_LOW:  prdata = PDATA_W'(cfg.phase_step_low);
      REG_CHUNK:     prdata = PDATA_W'(cfg.tone_chunk_frames);
      REG_VIB_ON:    prdata = PDATA_W'(cfg.vibrate_on_frames);
      REG_VIB_OFF:   prdata = PDATA_W'(cfg.vibrate_off_frames);
      REG_ALARM_LEN: prdata = PDATA_W'(cfg.alarm_length_frames);
      default:       prdata = '0;
    endcase
  end

endmodule

/* src/asvp_core.sv */
// Alarm sequencing state: elapsed count, tone chunks, phase accumulator and vibration pattern.
module asvp_core import asvp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  cfg_t                  cfg,
  input  logic                  advance,
  input  logic                  start_req,
  input  logic                  stop,
  output flags_t                flags,
  output logic [SINE_IDX_W-1:0] rom_idx
);

  logic                  running;
  logic [LEN_W-1:0]      elapsed_frames;
  logic [CHUNK_W-1:0]    chunk_frames_done;
  logic                  tone_is_high;
  logic [PHASE_BITS-1:0] phase_accumulator;
  logic [VIB_W-1:0]      vibrate_frames_done;
  logic                  vibrate_on;

  logic                  run;
  logic [LEN_W-1:0]      elapsed_cur;
  logic [CHUNK_W-1:0]    chunk_cur;
  logic                  tone_cur;
  logic [PHASE_BITS-1:0] phase_cur;
  logic [VIB_W-1:0]      vib_cur;
  logic                  von_cur;
  logic                  fin;
  logic [LEN_W-1:0]      len_eff;
  logic [CHUNK_W-1:0]    chunk_lim;
  logic [VIB_W-1:0]      vib_lim;
  logic [STEP_W-1:0]     step_sel;
  logic [PHASE_BITS-1:0] step_eff;
  logic [CHUNK_W-1:0]    chunk_inc;
  logic [VIB_W-1:0]      vib_inc;
  logic                  chunk_done;
  logic                  vib_done;

  logic                  running_next;
  logic [LEN_W-1:0]      elapsed_frames_next;
  logic [CHUNK_W-1:0]    chunk_frames_done_next;
  logic                  tone_is_high_next;
  logic [PHASE_BITS-1:0] phase_accumulator_next;
  logic [VIB_W-1:0]      vibrate_frames_done_next;
  logic                  vibrate_on_next;

  always_comb begin
    // A start request restarts every counter before the frame is played.
    run         = !stop && (start_req || running);
    elapsed_cur = start_req ? '0 : elapsed_frames;
    chunk_cur   = start_req ? '0 : chunk_frames_done;
    tone_cur    = start_req ? 1'b1 : tone_is_high;
    phase_cur   = start_req ? '0 : phase_accumulator;
    vib_cur     = start_req ? '0 : vibrate_frames_done;
    von_cur     = start_req ? 1'b1 : vibrate_on;

    len_eff   = (cfg.alarm_length_frames == '0) ? LEN_W'(1) : cfg.alarm_length_frames;
    chunk_lim = (cfg.tone_chunk_frames == '0) ? CHUNK_W'(1) : cfg.tone_chunk_frames;
    if (von_cur) vib_lim = cfg.vibrate_on_frames;
    else vib_lim = cfg.vibrate_off_frames;
    if (vib_lim == '0) vib_lim = VIB_W'(1);

    fin = ({1'b0, elapsed_cur} + (LEN_W + 1)'(1)) >= {1'b0, len_eff};

    rom_idx = phase_cur[PHASE_BITS-1 -: SINE_IDX_W];
    flags.active      = run;
    flags.motor_pulse = run && von_cur && (vib_cur == '0);
    flags.vibrating   = run && von_cur;
    flags.finished    = run && fin;

    step_sel  = tone_cur ? cfg.phase_step_high : cfg.phase_step_low;
    step_eff  = PHASE_BITS'(32'(step_sel) >> (32 - PHASE_BITS));
    chunk_inc = chunk_cur + CHUNK_W'(1);
    vib_inc   = vib_cur + VIB_W'(1);
    // A counter that wraps to zero also ends its interval.
    chunk_done = (chunk_inc == '0) || (chunk_inc >= chunk_lim);
    vib_done   = (vib_inc == '0) || (vib_inc >= vib_lim);

    running_next             = run && !fin;
    elapsed_frames_next      = elapsed_frames;
    chunk_frames_done_next   = chunk_frames_done;
    tone_is_high_next        = tone_is_high;
    phase_accumulator_next   = phase_accumulator;
    vibrate_frames_done_next = vibrate_frames_done;
    vibrate_on_next          = vibrate_on;
    if (run) begin
      elapsed_frames_next      = elapsed_cur + LEN_W'(1);
      chunk_frames_done_next   = chunk_done ? '0 : chunk_inc;
      tone_is_high_next        = chunk_done ? !tone_cur : tone_cur;
      phase_accumulator_next   = chunk_done ? '0 : phase_cur + step_eff;
      vibrate_frames_done_next = vib_done ? '0 : vib_inc;
      vibrate_on_next          = vib_done ? !von_cur : von_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running             <= 1'b0;
      elapsed_frames      <= '0;
      chunk_frames_done   <= '0;
      tone_is_high        <= 1'b1;
      phase_accumulator   <= '0;
      vibrate_frames_done <= '0;
      vibrate_on          <= 1'b0;
    end else if (advance) begin
      running             <= running_next;
      elapsed_frames      <= elapsed_frames_next;
      chunk_frames_done   <= chunk_frames_done_next;
      tone_is_high        <= tone_is_high_next;
      phase_accumulator   <= phase_accumulator_next;
      vibrate_frames_done <= vibrate_frames_done_next;
      vibrate_on          <= vibrate_on_next;
    end
  end

endmodule

/* src/alarm_siren_and_vibration_pattern_unit.sv */
// Top level of the two-tone alarm siren and vibration pattern unit.
// Each input word is one audio frame tick carrying start_req and stop; each
// accepted word gives exactly one result word: sample, active, motor_pulse,
// vibrating and finished. Both channels use valid and stall, and a word moves
// on a rising edge with valid high and stall low.
// Each result is registered in the output register, or in the skid register
// when the output stalls. Throughput is one word per cycle while in_stall is
// low, set by the single registered pass through sequencing and sine ROM read.
// Behind the output register sits a one-word skid register, so a word is still
// accepted while a result waits; in_stall rises only once that skid word is
// also held, and falls as soon as the receiver takes a result.
// Reset clears the alarm to idle, empties both result registers and loads
// the register defaults (phase steps 0, every frame count 1).
// Registers are written over the APB-style port at byte address 4*index; the
// user must write them only while no word is in flight: the block does not enforce it.
module alarm_siren_and_vibration_pattern_unit import asvp_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       start_req,
  input  logic                       stop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [SAMPLE_W-1:0] sample,
  output logic                       active,
  output logic                       motor_pulse,
  output logic                       vibrating,
  output logic                       finished,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [PADDR_W-1:0]         paddr,
  input  logic [PDATA_W-1:0]         pwdata,
  output logic [PDATA_W-1:0]         prdata,
  output logic                       pready
);

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    flags_t                     flags;
  } res_t;

  localparam sine_rom_t SINE_ROM = build_sine_rom();

  cfg_t                  cfg;
  flags_t                flags;
  logic [SINE_IDX_W-1:0] rom_idx;
  logic                  accept;
  logic                  out_free;
  logic                  skid_valid;
  res_t                  out_res;
  res_t                  skid_res;

  assign in_stall = skid_valid;
  assign accept   = in_valid && !skid_valid;
  assign out_free = !out_valid || !out_stall;

  asvp_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  asvp_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .advance   (accept),
    .start_req (start_req),
    .stop      (stop),
    .flags     (flags),
    .rom_idx   (rom_idx)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      out_valid  <= skid_valid || accept;
      skid_valid <= 1'b0;
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  // Result payload; the ROM word goes to whichever register takes the new word.
  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_res <= skid_res;
      end else if (accept) begin
        out_res.sample <= SINE_ROM[rom_idx];
        out_res.flags  <= flags;
      end
    end else if (accept) begin
      skid_res.sample <= SINE_ROM[rom_idx];
      skid_res.flags  <= flags;
    end
  end

  assign sample      = out_res.flags.active ? out_res.sample : '0;
  assign active      = out_res.flags.active;
  assign motor_pulse = out_res.flags.motor_pulse;
  assign vibrating   = out_res.flags.vibrating;
  assign finished    = out_res.flags.finished;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid word held while the output register is empty");

  a_skid_only_on_stall: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && out_stall))
    else $error("skid register filled although the output was free");

  a_finish_active: assert property (@(posedge clk) disable iff (rst)
    out_valid && finished |-> active)
    else $error("finished shown on an idle frame");

  a_pulse_vibrating: assert property (@(posedge clk) disable iff (rst)
    out_valid && motor_pulse |-> vibrating && active)
    else $error("motor pulse outside a vibration on phase");

endmodule
